/* design/quadrotor_rate_mixer_slew_top_macros.svh */
// Assertion helpers shared by the design files.
`ifndef QUADROTOR_RATE_MIXER_SLEW_TOP_MACROS_SVH
`define QUADROTOR_RATE_MIXER_SLEW_TOP_MACROS_SVH

`define QRMS_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define QRMS_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* design/qrms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package qrms_pkg;
	localparam int SpeedW = 10;
	localparam int NumMotors = 4;
	localparam int AddrW = 5;

	localparam logic [19:0] GainPitchRst = 20'd60000;
	localparam logic [19:0] GainRollRst = 20'd60000;
	localparam logic [19:0] GainYawRst = 20'd240000;
	localparam logic [15:0] LiftScaleRst = 16'd4500;
	localparam logic [9:0] MinSpeedRst = 10'd0;
	localparam logic [9:0] MaxSpeedRst = 10'd1023;
	localparam logic [9:0] SlewStepRst = 10'd16;

	localparam logic [2:0] RegGainPitch = 3'd0;
	localparam logic [2:0] RegGainRoll = 3'd1;
	localparam logic [2:0] RegGainYaw = 3'd2;
	localparam logic [2:0] RegLiftScale = 3'd3;
	localparam logic [2:0] RegMinSpeed = 3'd4;
	localparam logic [2:0] RegMaxSpeed = 3'd5;
	localparam logic [2:0] RegSlewStep = 3'd6;

	typedef struct packed {
		logic [15:0] lift;
		logic signed [15:0] pitch_target;
		logic signed [15:0] roll_target;
		logic signed [15:0] yaw_rate_target;
		logic signed [15:0] rate_p;
		logic signed [15:0] rate_q;
		logic signed [15:0] rate_r;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
	} in_item_t;

	typedef struct packed {
		logic [9:0] motor_front;
		logic [9:0] motor_right;
		logic [9:0] motor_back;
		logic [9:0] motor_left;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic [39:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [19:0] root;
	} sqrt_rsp_t;
endpackage
`default_nettype wire

/* design/qrms_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
module qrms_sqrt
	import qrms_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire sqrt_req_t req,
	output sqrt_rsp_t rsp
);
	logic [39:0] rem_q;
	logic [19:0] root_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [21:0] trial;

	always_comb begin
		trial = {root_q, 2'b01};
	end

	logic [41:0] acc_q;
	logic [41:0] acc_next;
	logic [41:0] sub;
	always_comb begin
		acc_next = {acc_q[39:0], rem_q[39:38]};
		sub = acc_next - {20'd0, trial};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == 5'd19) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.radicand;
			root_q <= '0;
			acc_q <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_q[37:0], 2'b00};
			if (!sub[41]) begin
				acc_q <= sub;
				root_q <= {root_q[18:0], 1'b1};
			end else begin
				acc_q <= acc_next;
				root_q <= {root_q[18:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.root = root_q;

	`include "quadrotor_rate_mixer_slew_top_macros.svh"
	`QRMS_ASSERT_IMP(a_done_after_busy, done_q, !busy_q, "Root reported while still busy.")
	`QRMS_ASSERT(a_no_restart, !(req.start && busy_q), "Root restarted while busy.")
	`QRMS_ASSERT(a_cnt_range, cnt_q <= 5'd19, "Root step count out of range.")
endmodule
`default_nettype wire

/* design/quadrotor_rate_mixer_slew_top.sv */
// Channel | Signals                           | Direction
// in      | in_valid, in_ready, in_data       | request into block
// out     | out_valid, out_ready, out_data    | result from block
// cfg     | psel, penable, pwrite, paddr ...  | register access
// A request with nonzero lift sets out_valid after five passes of one shared
// multiplier, then per motor a 20-step root, or no root when the demand is at or
// below min_speed. A zero-lift request only steps each motor speed down by slew_step,
// not below zero. in_ready is low from acceptance until the result is loaded into the
// output register; out_ready stalls hold the result there.
// Reset clears the motor speeds and the registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module quadrotor_rate_mixer_slew_top
	import qrms_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output out_item_t out_data,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [AddrW-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam logic [3:0] StIdle = 4'd0, StErr = 4'd1, StMul = 4'd2, StMix = 4'd3,
		StSqStart = 4'd4, StSqWait = 4'd5, StSlew = 4'd6, StOut = 4'd7, StZero = 4'd8;
	localparam int MW = $clog2(NumMotors);

	logic [19:0] gain_pitch_q, gain_roll_q, gain_yaw_q;
	logic [15:0] lift_scale_q;
	logic [9:0] min_speed_q, max_speed_q, slew_step_q;
	logic [9:0] speed_q [NumMotors];
	logic [3:0] state_q;
	logic [2:0] mstep_q;
	logic [MW-1:0] midx_q;
	in_item_t item_q;
	logic signed [17:0] ep_q, er_q, ey_q;
	logic signed [63:0] mp_q, mr_q, my_q, l_q;
	logic signed [63:0] prod_q;
	logic signed [32:0] ma_q, mb_q;
	logic signed [63:0] dem_q;
	logic dem_low;
	logic [9:0] tgt_q;
	logic out_valid_q;
	out_item_t out_q;
	sqrt_req_t sq_req;
	sqrt_rsp_t sq_rsp;

	assign pready = 1'b1;
	wire cfg_wr = psel & penable & pwrite;
	wire [2:0] ridx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_pitch_q <= GainPitchRst;
			gain_roll_q <= GainRollRst;
			gain_yaw_q <= GainYawRst;
			lift_scale_q <= LiftScaleRst;
			min_speed_q <= MinSpeedRst;
			max_speed_q <= MaxSpeedRst;
			slew_step_q <= SlewStepRst;
		end else if (cfg_wr) begin
			case (ridx)
				RegGainPitch: gain_pitch_q <= pwdata[19:0];
				RegGainRoll: gain_roll_q <= pwdata[19:0];
				RegGainYaw: gain_yaw_q <= pwdata[19:0];
				RegLiftScale: lift_scale_q <= pwdata[15:0];
				RegMinSpeed: min_speed_q <= pwdata[9:0];
				RegMaxSpeed: max_speed_q <= pwdata[9:0];
				RegSlewStep: slew_step_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			RegGainPitch: prdata = {12'd0, gain_pitch_q};
			RegGainRoll: prdata = {12'd0, gain_roll_q};
			RegGainYaw: prdata = {12'd0, gain_yaw_q};
			RegLiftScale: prdata = {16'd0, lift_scale_q};
			RegMinSpeed: prdata = {22'd0, min_speed_q};
			RegMaxSpeed: prdata = {22'd0, max_speed_q};
			RegSlewStep: prdata = {22'd0, slew_step_q};
			default: prdata = '0;
		endcase
	end

	// The magnitude is divided by a reciprocal multiply and the sign put back.
	function automatic logic signed [16:0] div10(logic signed [15:0] x);
		logic [15:0] mag;
		logic [31:0] prod;
		mag = x[15] ? 16'(-x) : 16'(x);
		prod = 32'(mag) * 32'd52429;
		return x[15] ? -17'(prod[31:19]) : 17'(prod[31:19]);
	endfunction

	function automatic logic signed [16:0] div7(logic signed [15:0] x);
		logic [15:0] mag;
		logic [31:0] prod;
		mag = x[15] ? 16'(-x) : 16'(x);
		prod = 32'(mag) * 32'd37450;
		return x[15] ? -17'(prod[31:18]) : 17'(prod[31:18]);
	endfunction

	// Truncating constant divisions of 16-bit values.
	logic signed [16:0] pt10, ax7, ay8;
	always_comb begin
		pt10 = div10(item_q.pitch_target);
		ax7 = div7(item_q.accel_x);
		ay8 = 17'(item_q.accel_y / 16'sd8);
	end
	logic signed [16:0] rt10;
	assign rt10 = div10(item_q.roll_target);

	always_comb begin
		case (mstep_q)
			3'd0: begin
				ma_q = 33'(signed'({1'b0, gain_pitch_q}));
				mb_q = 33'(ep_q);
			end
			3'd1: begin
				ma_q = 33'(signed'({1'b0, gain_roll_q}));
				mb_q = 33'(er_q);
			end
			3'd2: begin
				ma_q = 33'(signed'({1'b0, gain_yaw_q}));
				mb_q = 33'(ey_q);
			end
			default: begin
				ma_q = 33'(signed'({1'b0, lift_scale_q}));
				mb_q = 33'(signed'({1'b0, item_q.lift}));
			end
		endcase
	end

	logic signed [63:0] mix_sum;
	always_comb begin
		case (midx_q)
			2'd0: mix_sum = l_q - 2 * mp_q + my_q;
			2'd1: mix_sum = l_q + 2 * mr_q - my_q;
			2'd2: mix_sum = l_q + 2 * mp_q + my_q;
			default: mix_sum = l_q - 2 * mr_q - my_q;
		endcase
	end

	assign dem_low = (dem_q <= 64'(signed'({1'b0, min_speed_q})));

	logic signed [11:0] cur, tg, st;
	always_comb begin
		cur = 12'(signed'({1'b0, speed_q[midx_q]}));
		tg = 12'(signed'({1'b0, tgt_q}));
		st = 12'(signed'({1'b0, slew_step_q}));
	end

	logic [9:0] floor_root;
	always_comb begin
		floor_root = (sq_rsp.root > 20'(max_speed_q)) ? max_speed_q : sq_rsp.root[9:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			out_valid_q <= 1'b0;
			mstep_q <= '0;
			midx_q <= '0;
			for (int i = 0; i < NumMotors; i++) speed_q[i] <= '0;
		end else begin
			if (state_q == StOut && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				StIdle: if (in_valid && in_ready) begin
					state_q <= (in_data.lift == 16'd0) ? StZero : StErr;
				end
				StErr: begin
					mstep_q <= '0;
					state_q <= StMul;
				end
				StMul: begin
					mstep_q <= mstep_q + 3'd1;
					if (mstep_q == 3'd4) begin
						midx_q <= '0;
						state_q <= StMix;
					end
				end
				StMix: state_q <= StSqStart;
				StSqStart: begin
					if (dem_low) begin
						state_q <= StSlew;
					end else begin
						state_q <= StSqWait;
					end
				end
				StSqWait: if (sq_rsp.done) state_q <= StSlew;
				StSlew: begin
					if (tg - cur > st) speed_q[midx_q] <= 10'(cur + st);
					else if (cur - tg > st) speed_q[midx_q] <= 10'(cur - st);
					else speed_q[midx_q] <= tgt_q;
					midx_q <= midx_q + 1'b1;
					state_q <= (midx_q == MW'(NumMotors - 1)) ? StOut : StMix;
				end
				StZero: begin
					for (int i = 0; i < NumMotors; i++)
						speed_q[i] <= (speed_q[i] < slew_step_q) ? 10'd0 :
							speed_q[i] - slew_step_q;
					state_q <= StOut;
				end
				StOut: if (!out_valid_q || out_ready) begin
					state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == StIdle && in_valid && in_ready) item_q <= in_data;
		if (state_q == StErr) begin
			ep_q <= 18'(pt10) - 18'(item_q.rate_q) + 18'(ax7);
			er_q <= 18'(rt10) - 18'(item_q.rate_p) - 18'(ay8);
			ey_q <= 18'(item_q.yaw_rate_target) - 18'(item_q.rate_r);
		end
		if (state_q == StMul) begin
			prod_q <= 64'(ma_q * mb_q);
			case (mstep_q)
				3'd1: mp_q <= prod_q;
				3'd2: mr_q <= prod_q;
				3'd3: my_q <= prod_q;
				3'd4: l_q <= prod_q;
				default: ;
			endcase
		end
		if (state_q == StMix) dem_q <= mix_sum / 64'sd4;
		if (state_q == StSqStart && dem_low)
			tgt_q <= (min_speed_q > max_speed_q) ? max_speed_q : min_speed_q;
		if (state_q == StSqWait && sq_rsp.done) tgt_q <= floor_root;
		if (state_q == StOut && (!out_valid_q || out_ready)) begin
			out_q.motor_front <= speed_q[0];
			out_q.motor_right <= speed_q[1];
			out_q.motor_back <= speed_q[2];
			out_q.motor_left <= speed_q[3];
		end
	end

	assign sq_req.start = (state_q == StSqStart) && !dem_low;
	assign sq_req.radicand = dem_q[39:0];

	qrms_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.req(sq_req),
		.rsp(sq_rsp)
	);

	assign in_ready = (state_q == StIdle);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`include "quadrotor_rate_mixer_slew_top_macros.svh"
	`QRMS_ASSERT_IMP(a_accept_leaves_idle, in_valid && in_ready, state_q != StIdle,
		"Request accepted but sequencer stayed idle.")
	`QRMS_ASSERT_IMP(a_out_hold, out_valid_q && !out_ready, out_valid_q,
		"Result dropped while stalled.")
	`QRMS_ASSERT(a_wait_busy, !(state_q == StSqWait && !sq_rsp.busy && !sq_rsp.done),
		"Root wait without a running root.")
endmodule
`default_nettype wire

/* dv/quadrotor_rate_mixer_slew_top_tb.sv */
`timescale 1ns / 1ps
module quadrotor_rate_mixer_slew_top_tb;
	import qrms_pkg::*;

	localparam int WatchdogLimit = 20000;
	localparam logic [2:0] RegUnused = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic [19:0] gain_p, gain_r, gain_y;
	logic [15:0] scale;
	logic [9:0] floor_spd, ceil_spd, step_spd;
	logic [9:0] speed [4];
	out_item_t speeds_q [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors = 0;
	int idle_cycles = 0;
	int requests_sent = 0;
	int results_checked = 0;

	quadrotor_rate_mixer_slew_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	function automatic longint isqrt(longint n);
		longint r;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			longint t;
			t = r | (longint'(1) << b);
			if (t * t <= n) begin
				r = t;
			end
		end
		return r;
	endfunction

	function automatic logic [9:0] slew_to(logic [9:0] cur, longint tgt);
		longint c;
		longint s;
		c = longint'(cur);
		s = longint'(step_spd);
		if (tgt - c > s) begin
			return 10'(c + s);
		end else if (c - tgt > s) begin
			return 10'(c - s);
		end
		return 10'(tgt);
	endfunction

	task automatic predict_speeds(in_item_t it);
		longint ep, er, ey, mp, mr, my, l, t;
		longint d [4];
		out_item_t o;
		if (it.lift == 0) begin
			for (int i = 0; i < 4; i++) begin
				speed[i] = (speed[i] < step_spd) ? 10'd0 : speed[i] - step_spd;
			end
		end else begin
			ep = longint'(it.pitch_target) / 10 - longint'(it.rate_q) + longint'(it.accel_x) / 7;
			er = longint'(it.roll_target) / 10 - longint'(it.rate_p) - longint'(it.accel_y) / 8;
			ey = longint'(it.yaw_rate_target) - longint'(it.rate_r);
			mp = longint'(gain_p) * ep;
			mr = longint'(gain_r) * er;
			my = longint'(gain_y) * ey;
			l = longint'(scale) * longint'(it.lift);
			d[0] = (l - 2 * mp + my) / 4;
			d[1] = (l + 2 * mr - my) / 4;
			d[2] = (l + 2 * mp + my) / 4;
			d[3] = (l - 2 * mr - my) / 4;
			for (int i = 0; i < 4; i++) begin
				t = (d[i] <= longint'(floor_spd)) ? longint'(floor_spd) : isqrt(d[i]);
				if (t > longint'(ceil_spd)) begin
					t = longint'(ceil_spd);
				end
				speed[i] = slew_to(speed[i], t);
			end
		end
		o.motor_front = speed[0];
		o.motor_right = speed[1];
		o.motor_back = speed[2];
		o.motor_left = speed[3];
		speeds_q.push_back(o);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= AddrW'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			RegGainPitch: gain_p = val[19:0];
			RegGainRoll: gain_r = val[19:0];
			RegGainYaw: gain_y = val[19:0];
			RegLiftScale: scale = val[15:0];
			RegMinSpeed: floor_spd = val[9:0];
			RegMaxSpeed: ceil_spd = val[9:0];
			RegSlewStep: step_spd = val[9:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_request(in_item_t it);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do begin
			@(posedge clk);
		end while (!in_ready);
		predict_speeds(it);
		requests_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (speeds_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (150) @(posedge clk);
	endtask

	function automatic in_item_t random_request(bit allow_zero);
		in_item_t it;
		it = in_item_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
		case ($urandom_range(3))
			0: it.lift = 16'($urandom_range(1, 200));
			1: it.lift = (allow_zero && $urandom_range(1)) ? 16'd0 : 16'($urandom);
			default: it.lift = 16'($urandom_range(1, 5000));
		endcase
		if ($urandom_range(2) != 0) begin
			it.pitch_target = 16'(int'($urandom_range(200)) - 100);
			it.roll_target = 16'(int'($urandom_range(200)) - 100);
			it.yaw_rate_target = 16'(int'($urandom_range(40)) - 20);
			it.rate_p = 16'(int'($urandom_range(40)) - 20);
			it.rate_q = 16'(int'($urandom_range(40)) - 20);
			it.rate_r = 16'(int'($urandom_range(20)) - 10);
			it.accel_x = 16'(int'($urandom_range(200)) - 100);
			it.accel_y = 16'(int'($urandom_range(200)) - 100);
		end
		return it;
	endfunction

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (speeds_q.size() == 0) begin
				$error("result with no request pending: %h", out_data);
				errors++;
			end else begin
				out_item_t e;
				e = speeds_q.pop_front();
				if (out_data.motor_front !== e.motor_front) begin
					$error("motor_front expected %0d got %0d", e.motor_front, out_data.motor_front);
					errors++;
				end
				if (out_data.motor_right !== e.motor_right) begin
					$error("motor_right expected %0d got %0d", e.motor_right, out_data.motor_right);
					errors++;
				end
				if (out_data.motor_back !== e.motor_back) begin
					$error("motor_back expected %0d got %0d", e.motor_back, out_data.motor_back);
					errors++;
				end
				if (out_data.motor_left !== e.motor_left) begin
					$error("motor_left expected %0d got %0d", e.motor_left, out_data.motor_left);
					errors++;
				end
			end
			results_checked++;
		end
		out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WatchdogLimit) begin
			$display("watchdog: no progress for %0d cycles", WatchdogLimit);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic test_directed();
		in_item_t it;
		it = '0;
		it.lift = 16'hFFFF;
		repeat (3) send_request(it);
		it = '0;
		repeat (2) send_request(it);
		it = '{16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
			16'sh8000, 16'sh7FFF, 16'sh8000};
		send_request(it);
		it = '{16'd1, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
			16'sh7FFF, 16'sh8000, 16'sh7FFF};
		send_request(it);
		it = '{16'd3000, -16'sd15, 16'sd17, 16'sd0, 16'sd1, -16'sd1, -16'sd13, 16'sd9, -16'sd15};
		repeat (4) send_request(it);
		it.lift = 16'hFFFF;
		it.rate_r = 16'sh7FFF;
		send_request(it);
		drain();
		write_reg(RegSlewStep, 32'd0);
		it.lift = 16'd3000;
		send_request(it);
		it = '0;
		send_request(it);
		drain();
		write_reg(RegMinSpeed, 32'd900);
		write_reg(RegMaxSpeed, 32'd100);
		write_reg(RegSlewStep, 32'd1023);
		it.lift = 16'd500;
		repeat (2) send_request(it);
		drain();
		write_reg(RegUnused, 32'hFFFF_FFFF);
		it = '0;
		send_request(it);
		drain();
	endtask

	task automatic test_random_phase(int n, int sidle, int ridle);
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		write_reg(RegGainPitch, $urandom_range(3) == 0 ? 32'hFFFFF : 32'($urandom_range(120000)));
		write_reg(RegGainRoll, $urandom_range(3) == 0 ? 32'd0 : 32'($urandom_range(120000)));
		write_reg(RegGainYaw, 32'($urandom_range(500000)));
		write_reg(RegLiftScale, $urandom_range(3) == 0 ? 32'hFFFF : 32'($urandom_range(9000)));
		write_reg(RegMinSpeed, 32'($urandom_range(3) == 0 ? $urandom_range(1023) : $urandom_range(50)));
		write_reg(RegMaxSpeed, 32'($urandom_range(3) == 0 ? $urandom_range(1023) : $urandom_range(800, 1023)));
		write_reg(RegSlewStep, 32'($urandom_range(1, 1023)));
		for (int i = 0; i < n; i++) begin
			send_request(random_request(1'b1));
		end
		drain();
	endtask

	task automatic test_reset_defaults();
		write_reg(RegGainPitch, 32'(GainPitchRst));
		write_reg(RegGainRoll, 32'(GainRollRst));
		write_reg(RegGainYaw, 32'(GainYawRst));
		write_reg(RegLiftScale, 32'(LiftScaleRst));
		write_reg(RegMinSpeed, 32'(MinSpeedRst));
		write_reg(RegMaxSpeed, 32'(MaxSpeedRst));
		write_reg(RegSlewStep, 32'(SlewStepRst));
		for (int i = 0; i < 150; i++) begin
			send_request(random_request(1'b0));
		end
		drain();
	endtask

	initial begin
		gain_p = GainPitchRst;
		gain_r = GainRollRst;
		gain_y = GainYawRst;
		scale = LiftScaleRst;
		floor_spd = MinSpeedRst;
		ceil_spd = MaxSpeedRst;
		step_spd = SlewStepRst;
		for (int i = 0; i < 4; i++) begin
			speed[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		for (int k = 0; k < 3; k++) begin
			test_random_phase(150, 36, 77);
		end
		for (int k = 0; k < 3; k++) begin
			test_random_phase(150, 77, 36);
		end
		for (int k = 0; k < 3; k++) begin
			test_random_phase(150, 0, 0);
		end
		test_reset_defaults();
		$display("Sent %0d requests and checked %0d results over ten register settings.",
			requests_sent, results_checked);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

/* quadrotor_rate_mixer_slew_top.f */
+incdir+design
design/qrms_pkg.sv
design/qrms_sqrt.sv
design/quadrotor_rate_mixer_slew_top.sv
dv/quadrotor_rate_mixer_slew_top_tb.sv
